### hw/rtl/lzw_stream_decoder_defines.svh
// ---------------------------------------------------------------------------
// LZW stream decoder assertion macros
// Shared helpers for the concurrent checks of the decoder.
// ---------------------------------------------------------------------------
`ifndef LZW_STREAM_DECODER_DEFINES_SVH
`define LZW_STREAM_DECODER_DEFINES_SVH

// same-cycle implication, off during reset
`define LZW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define LZW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked also across reset
`define LZW_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/lzw_pkg.sv
// ---------------------------------------------------------------------------
// LZW decoder package
// Codes, status values, sizes and sequencer states of the decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package lzw_pkg;

   localparam int TABLE_ENTRIES_DEF = 4096;
   localparam int STACK_SIZE        = 4096;
   localparam int STACK_AW          = 12;

   localparam logic [11:0] CODE_CLEAR = 12'h100;
   localparam logic [11:0] CODE_END   = 12'h101;
   localparam logic [12:0] FIRST_FREE = 13'd257;
   localparam logic [3:0]  WIDTH_MIN  = 4'd9;

   localparam logic [0:0] CMD_PUSH = 1'b0;
   localparam logic [0:0] CMD_PULL = 1'b1;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_REFUSED = 3'd1;
   localparam logic [2:0] ST_EMPTY   = 3'd2;
   localparam logic [2:0] ST_ERROR   = 3'd3;
   localparam logic [2:0] ST_ENDED   = 3'd4;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_PULL  = 10'b0000000010,
      S_CHECK = 10'b0000000100,
      S_CODE  = 10'b0000001000,
      S_FIRST = 10'b0000010000,
      S_FSEL  = 10'b0000100000,
      S_BASE  = 10'b0001000000,
      S_EXP   = 10'b0010000000,
      S_EXPW  = 10'b0100000000,
      S_RESP  = 10'b1000000000
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/lzw_stream_decoder.sv
// ---------------------------------------------------------------------------
// LZW stream decoder
// PDF-style LZW decoder, 9 to 12 bit MSB-first codes, early width change.
// ---------------------------------------------------------------------------
// Push items carry one compressed byte, pull items return one decoded byte;
// every item gives exactly one result. The input is ready only while the
// sequencer idles. A push that is not refused or ignored, and a pull that
// empties the stack, start decoding; decoding runs only while the stack is
// empty. A clear, end or missing code walks no string, any other code walks
// the string it names (for a code not yet in the table, the previous code's
// string) byte by byte, since the prefix chain is walked one link at a time
// through the single read port of the table memories. A finished result
// waits in the output register until the receiver takes it, and the next
// result waits in the sequencer behind it. Table and stack memories need no
// clearing pass after reset.
`default_nettype none

module lzw_stream_decoder
   import lzw_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,  // in_byte
   input  wire logic       req_tuser,  // command
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,  // out_byte
   output logic [4:0]      rsp_tuser   // out_valid, status[2:0], more_pending
);

   localparam int TW = $clog2(TABLE_ENTRIES);

   // table and stack memories
   logic [11:0] prefix_mem [TABLE_ENTRIES];
   logic [7:0]  suffix_mem [TABLE_ENTRIES];
   logic [7:0]  first_mem  [TABLE_ENTRIES];
   logic [7:0]  stack_mem  [STACK_SIZE];

   state_type   state_ff, state_in;
   logic [23:0] buf_ff, buf_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [3:0]  width_ff, width_in;
   logic [12:0] next_ff, next_in;
   logic [11:0] prev_ff, prev_in;
   logic [7:0]  lfb_ff, lfb_in;
   logic        seen_ff, seen_in;
   logic [12:0] depth_ff, depth_in;
   logic        ended_ff, ended_in;
   logic        error_ff, error_in;
   logic [11:0] code_ff, code_in;
   logic [11:0] c_ff, c_in;
   logic [7:0]  f_ff, f_in;
   logic [7:0]  fb_ff, fb_in;
   logic        pushdec_ff, pushdec_in;
   logic [2:0]  status_ff, status_in;
   logic [7:0]  obyte_ff, obyte_in;
   logic        ovalid_ff, ovalid_in;
   logic        rvalid_ff, rvalid_in;
   logic [7:0]  rdata_ff, rdata_in;
   logic [4:0]  ruser_ff, ruser_in;

   logic [TW-1:0]       tbl_raddr;
   logic                tbl_we;
   logic [11:0]         prefix_rd_ff;
   logic [7:0]          suffix_rd_ff, first_rd_ff;
   logic                stk_we;
   logic [7:0]          stk_wdata;
   logic [STACK_AW-1:0] stk_raddr;
   logic [7:0]          stk_rd_ff;

   logic        accept;
   logic [11:0] code_x;
   logic [23:0] shifted;
   logic [11:0] base;
   logic [2:0]  fin_status;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = ruser_ff;

   // code extraction: one shifter
   assign shifted = buf_ff >> (cnt_ff - {1'b0, width_ff});
   assign code_x  = shifted[11:0] & (12'hFFF >> (4'd12 - width_ff));
   assign base    = ({1'b0, prev_ff} < next_ff) ? prev_ff : code_ff;
   assign fin_status = error_ff ? ST_ERROR : (ended_ff ? ST_ENDED : ST_OK);
   assign stk_raddr  = depth_ff[STACK_AW-1:0] - 1'b1;

   always_comb begin
      state_in   = state_ff;
      buf_in     = buf_ff;
      cnt_in     = cnt_ff;
      width_in   = width_ff;
      next_in    = next_ff;
      prev_in    = prev_ff;
      lfb_in     = lfb_ff;
      seen_in    = seen_ff;
      depth_in   = depth_ff;
      ended_in   = ended_ff;
      error_in   = error_ff;
      code_in    = code_ff;
      c_in       = c_ff;
      f_in       = f_ff;
      fb_in      = fb_ff;
      pushdec_in = pushdec_ff;
      status_in  = status_ff;
      obyte_in   = obyte_ff;
      ovalid_in  = ovalid_ff;
      rdata_in   = rdata_ff;
      ruser_in   = ruser_ff;
      rvalid_in  = rvalid_ff && !rsp_tready;
      tbl_raddr  = c_ff[TW-1:0];
      tbl_we     = 1'b0;
      stk_we     = 1'b0;
      stk_wdata  = lfb_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pushdec_in = 1'b0;
               obyte_in   = 8'd0;
               ovalid_in  = 1'b0;
               state_in   = S_RESP;
               if (req_tuser == CMD_PUSH) begin
                  if (error_ff) begin
                     status_in = ST_ERROR;
                  end else if (ended_ff) begin
                     status_in = ST_ENDED;
                  end else if (depth_ff != 13'd0) begin
                     status_in = ST_REFUSED;
                  end else begin
                     if (!seen_ff) begin
                        seen_in = 1'b1;
                        lfb_in  = req_tdata;
                     end
                     buf_in     = {buf_ff[15:0], req_tdata};
                     cnt_in     = cnt_ff + 5'd8;
                     pushdec_in = 1'b1;
                     state_in   = S_CHECK;
                  end
               end else begin
                  if (depth_ff != 13'd0) begin
                     depth_in = depth_ff - 13'd1;
                     state_in = S_PULL;
                  end else begin
                     status_in = fin_status == ST_OK ? ST_EMPTY : fin_status;
                  end
               end
            end
         end
         S_PULL: begin
            obyte_in  = stk_rd_ff;
            ovalid_in = 1'b1;
            status_in = ST_OK;
            state_in  = (depth_ff == 13'd0) ? S_CHECK : S_RESP;
         end
         S_CHECK: begin
            if (!error_ff && !ended_ff && depth_ff == 13'd0 &&
                cnt_ff >= {1'b0, width_ff}) begin
               state_in = S_CODE;
            end else begin
               state_in = S_RESP;
            end
         end
         S_CODE: begin
            cnt_in   = cnt_ff - {1'b0, width_ff};
            code_in  = code_x;
            c_in     = code_x;
            state_in = S_CHECK;
            if (code_x == CODE_CLEAR) begin
               width_in = WIDTH_MIN;
               next_in  = FIRST_FREE;
            end else if (code_x == CODE_END) begin
               ended_in = 1'b1;
            end else if ({1'b0, code_x} >= next_ff) begin
               if ({1'b0, prev_ff} >= next_ff) begin
                  error_in = 1'b1;
               end else begin
                  // code not yet in table: previous string plus its first byte
                  stk_we    = 1'b1;
                  stk_wdata = lfb_ff;
                  depth_in  = depth_ff + 13'd1;
                  c_in      = prev_ff;
                  state_in  = S_FIRST;
               end
            end else begin
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            tbl_raddr = c_ff[TW-1:0];
            state_in  = S_FSEL;
         end
         S_FSEL: begin
            f_in      = (c_ff < 12'd256) ? c_ff[7:0] : first_rd_ff;
            tbl_raddr = base[TW-1:0];
            state_in  = S_BASE;
         end
         S_BASE: begin
            fb_in    = (base < 12'd256) ? base[7:0] : first_rd_ff;
            state_in = S_EXP;
         end
         S_EXP: begin
            if (c_ff >= 12'd256) begin
               tbl_raddr = c_ff[TW-1:0];
               state_in  = S_EXPW;
            end else begin
               stk_we    = 1'b1;
               stk_wdata = c_ff[7:0];
               depth_in  = depth_ff + 13'd1;
               // string done: add the new entry
               lfb_in    = f_ff;
               prev_in   = code_ff;
               if (next_ff < 13'(TABLE_ENTRIES)) begin
                  tbl_we  = 1'b1;
                  next_in = next_ff + 13'd1;
                  if (next_ff == 13'd510 || next_ff == 13'd1022 || next_ff == 13'd2046) begin
                     width_in = width_ff + 4'd1;
                  end
               end
               state_in = S_CHECK;
            end
         end
         S_EXPW: begin
            stk_we    = 1'b1;
            stk_wdata = suffix_rd_ff;
            depth_in  = depth_ff + 13'd1;
            c_in      = prefix_rd_ff;
            state_in  = S_EXP;
         end
         S_RESP: begin
            if (!rvalid_ff || rsp_tready) begin
               rvalid_in = 1'b1;
               rdata_in  = obyte_ff;
               ruser_in  = {depth_ff != 13'd0,
                            pushdec_ff ? fin_status : status_ff, ovalid_ff};
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         buf_ff    <= 24'd0;
         cnt_ff    <= 5'd0;
         width_ff  <= WIDTH_MIN;
         next_ff   <= FIRST_FREE;
         prev_ff   <= 12'd0;
         lfb_ff    <= 8'd0;
         seen_ff   <= 1'b0;
         depth_ff  <= 13'd0;
         ended_ff  <= 1'b0;
         error_ff  <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         buf_ff    <= buf_in;
         cnt_ff    <= cnt_in;
         width_ff  <= width_in;
         next_ff   <= next_in;
         prev_ff   <= prev_in;
         lfb_ff    <= lfb_in;
         seen_ff   <= seen_in;
         depth_ff  <= depth_in;
         ended_ff  <= ended_in;
         error_ff  <= error_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff    <= code_in;
      c_ff       <= c_in;
      f_ff       <= f_in;
      fb_ff      <= fb_in;
      pushdec_ff <= pushdec_in;
      status_ff  <= status_in;
      obyte_ff   <= obyte_in;
      ovalid_ff  <= ovalid_in;
      rdata_ff   <= rdata_in;
      ruser_ff   <= ruser_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         prefix_mem[next_ff[TW-1:0]] <= base;
         suffix_mem[next_ff[TW-1:0]] <= f_ff;
         first_mem[next_ff[TW-1:0]]  <= fb_ff;
      end
      prefix_rd_ff <= prefix_mem[tbl_raddr];
      suffix_rd_ff <= suffix_mem[tbl_raddr];
      first_rd_ff  <= first_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[depth_ff[STACK_AW-1:0]] <= stk_wdata;
      end
      stk_rd_ff <= stack_mem[stk_raddr];
   end

endmodule

`default_nettype wire

### hw/rtl/lzw_checker.sv
// ---------------------------------------------------------------------------
// LZW decoder port checker
// Concurrent checks on the decoder ports, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "lzw_stream_decoder_defines.svh"

module lzw_checker
   import lzw_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [4:0] rsp_tuser
);

   logic        in_acc;
   logic        rsp_stall;
   logic [12:0] rsp_word;
   assign in_acc    = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tdata, rsp_tuser};

   `LZW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))
   `LZW_ASSERT_IMPLY(a_byte_ok, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tuser[3:1] == ST_OK)
   `LZW_ASSERT_IMPLY(a_no_byte_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == 8'd0)
   `LZW_ASSERT_NEXT(a_busy_after_acc, clock, reset, in_acc, !req_tready)
   `LZW_ASSERT_ALWAYS(a_reset_quiet, clock, reset, !rsp_tvalid)

endmodule

bind lzw_stream_decoder lzw_checker u_lzw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
